@@ rtl/track_box_vertex_extrapolator_top_defines.svh @@
// Assertion macros shared by the checker of the track box vertex extrapolator.
// Depends on nothing; expects clk_i and rst_ni in the scope of use.
`ifndef TRACK_BOX_VERTEX_EXTRAPOLATOR_TOP_DEFINES_SVH
`define TRACK_BOX_VERTEX_EXTRAPOLATOR_TOP_DEFINES_SVH

// Check a property outside reset.
`define TBVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TBVE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/tbve_pkg.sv @@
// Types, constants and slab arithmetic of the track box vertex extrapolator.
// Used by every module of the block; depends on nothing.
package tbve_pkg;

  localparam int CoordW  = 23;  // coordinate, signed
  localparam int HalfW   = 22;  // box half size, unsigned
  localparam int DirW    = 24;  // direction, signed
  localparam int BoundW  = 25;  // box bound, signed
  localparam int NumW    = 26;  // slab numerator, signed
  localparam int CrossW  = 51;  // cross product of two fractions
  localparam int ProdW   = 50;  // direction times numerator
  localparam int DivNW   = 51;  // dividend of the rounding divide
  localparam int DivDW   = 25;  // divisor of the rounding divide
  localparam int QuotW   = 24;  // quotient bits before saturation
  localparam int DivLat  = QuotW + 1;
  localparam int CfgIdxW = 8;
  localparam int InDataW  = 144;
  localparam int OutDataW = 72;
  localparam int FifoDepth = 4;

  localparam logic signed [CoordW-1:0] VMin = -(CoordW'(1) <<< (CoordW-1));
  localparam logic signed [CoordW-1:0] VMax = (CoordW'(1) <<< (CoordW-1)) - CoordW'(1);

  localparam logic signed [CoordW-1:0] RstCenterX = -CoordW'(80000);
  localparam logic signed [CoordW-1:0] RstCenterY = CoordW'(35000);
  localparam logic [HalfW-1:0]         RstHalfX   = HalfW'(50000);
  localparam logic [HalfW-1:0]         RstHalfY   = HalfW'(50000);
  localparam logic [HalfW-1:0]         RstHalfZ   = HalfW'(125);
  localparam logic signed [CoordW-1:0] RstLeftZ   = -CoordW'(450000);
  localparam logic signed [CoordW-1:0] RstRightZ  = CoordW'(450000);
  localparam logic signed [CoordW-1:0] RstCenterZ = CoordW'(0);

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 8'd0,
    REG_CENTER_Y = 8'd1,
    REG_HALF_X   = 8'd2,
    REG_HALF_Y   = 8'd3,
    REG_HALF_Z   = 8'd4,
    REG_LEFT_Z   = 8'd5,
    REG_RIGHT_Z  = 8'd6,
    REG_CENTER_BOX_Z = 8'd7
  } cfg_reg_e;

  // Origin and direction of one track.
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic signed [DirW-1:0]   dx;
    logic signed [DirW-1:0]   dy;
    logic signed [DirW-1:0]   dz;
  } track_t;

  // Track plus the bounds of both candidate boxes.
  typedef struct packed {
    track_t                   trk;
    logic signed [BoundW-1:0] xlo;
    logic signed [BoundW-1:0] xhi;
    logic signed [BoundW-1:0] ylo;
    logic signed [BoundW-1:0] yhi;
    logic signed [BoundW-1:0] zplo;
    logic signed [BoundW-1:0] zphi;
    logic signed [BoundW-1:0] zclo;
    logic signed [BoundW-1:0] zchi;
  } item_t;

  typedef struct packed {
    logic                   par;
    logic                   ok;
    logic signed [NumW-1:0] a;
    logic signed [NumW-1:0] b;
    logic [DirW-1:0]        den;
  } slab_t;

  typedef struct packed {
    logic                   pres;
    logic signed [NumW-1:0] num;
    logic [DirW-1:0]        den;
  } frac_t;

  // Entry and exit numerators of one slab.
  function automatic slab_t slab_f(logic signed [CoordW-1:0] p, logic signed [DirW-1:0] d,
                                   logic signed [BoundW-1:0] lo, logic signed [BoundW-1:0] hi);
    slab_t s;
    s.par = (d == '0);
    s.ok  = 1'b1;
    s.a   = '0;
    s.b   = '0;
    s.den = '0;
    if (d == '0) begin
      s.ok = !((BoundW'(p) < lo) || (BoundW'(p) > hi));
    end else if (!d[DirW-1]) begin
      s.a   = NumW'(lo) - NumW'(p);
      s.b   = NumW'(hi) - NumW'(p);
      s.den = d;
    end else begin
      s.a   = NumW'(p) - NumW'(hi);
      s.b   = NumW'(p) - NumW'(lo);
      s.den = DirW'(-d);
    end
    return s;
  endfunction

  function automatic frac_t near_f(slab_t s);
    frac_t f;
    f.pres = !s.par;
    f.num  = s.a;
    f.den  = s.den;
    return f;
  endfunction

  function automatic frac_t far_f(slab_t s);
    frac_t f;
    f.pres = !s.par;
    f.num  = s.b;
    f.den  = s.den;
    return f;
  endfunction

  // x > y by cross multiplication, both denominators positive.
  function automatic logic frac_gt(frac_t x, frac_t y);
    logic signed [CrossW-1:0] l;
    logic signed [CrossW-1:0] r;
    l = CrossW'(x.num) * CrossW'($signed({1'b0, y.den}));
    r = CrossW'(y.num) * CrossW'($signed({1'b0, x.den}));
    return l > r;
  endfunction

  function automatic frac_t max_f(frac_t x, frac_t y);
    frac_t r;
    r = x;
    if (!x.pres) r = y;
    else if (y.pres && frac_gt(y, x)) r = y;
    return r;
  endfunction

  function automatic frac_t min_f(frac_t x, frac_t y);
    frac_t r;
    r = x;
    if (!x.pres) r = y;
    else if (y.pres && frac_gt(x, y)) r = y;
    return r;
  endfunction

endpackage

@@ rtl/track_box_vertex_extrapolator_top.sv @@
// Top level of the track box vertex extrapolator: front, queue and back part.
// Depends on tbve_pkg, tbve_front, tbve_fifo, tbve_back.
//
// Intersects the line through a front and a back hit with the primary box of
// the track's arm and, failing that, the centre box, and returns the near entry
// point. One track is accepted per clock unless the queue is full and the
// front stage holds a track. The rounded vertex is formed by a restoring
// divider with a load stage and 24 quotient stages. The back part halts as a
// whole while a result waits, and a four-item queue takes tracks from the front
// part meanwhile. Box registers are written at any time through the
// configuration channel, which is always ready.
module track_box_vertex_extrapolator_top #(
  parameter int FifoDepth = tbve_pkg::FifoDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tbve_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tbve_pkg::CoordW-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // front_x, front_y, front_z, back_x, back_y, back_z, 23 bits each, zero pad
  input  logic [tbve_pkg::InDataW-1:0]       s_axis_tdata_i,
  // side
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // vertex_x, vertex_y, vertex_z, 23 bits each, zero pad
  output logic [tbve_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // found, which_box
  output logic [1:0]                         m_axis_tuser_o
);

  tbve_pkg::item_t push_item, pop_item;
  logic push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  tbve_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .side_i      (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .push_o      (push),
    .full_i      (full),
    .item_o      (push_item)
  );

  tbve_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_item)
  );

  tbve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_user_o  (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

@@ rtl/tbve_front.sv @@
// Front part: holds the box registers, accepts tracks and forms box bounds.
// Depends on tbve_pkg.
module tbve_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tbve_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tbve_pkg::CoordW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                side_i,
  input  logic [tbve_pkg::InDataW-1:0]        in_data_i,
  output logic                                push_o,
  input  logic                                full_i,
  output tbve_pkg::item_t                     item_o
);

  logic signed [tbve_pkg::CoordW-1:0] cx_q, cy_q, lz_q, rz_q, cz_q;
  logic [tbve_pkg::HalfW-1:0]         hx_q, hy_q, hz_q;
  logic                               f_v_q;
  tbve_pkg::item_t                    f_q, f_d;
  logic signed [tbve_pkg::CoordW-1:0] fx, fy, fz, bx, by, bz, zp;
  logic signed [tbve_pkg::BoundW-1:0] hxs, hys, hzs;
  logic                               acc;

  // Write box registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= tbve_pkg::RstCenterX;
      cy_q <= tbve_pkg::RstCenterY;
      hx_q <= tbve_pkg::RstHalfX;
      hy_q <= tbve_pkg::RstHalfY;
      hz_q <= tbve_pkg::RstHalfZ;
      lz_q <= tbve_pkg::RstLeftZ;
      rz_q <= tbve_pkg::RstRightZ;
      cz_q <= tbve_pkg::RstCenterZ;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tbve_pkg::REG_CENTER_X:     cx_q <= cfg_data_i;
        tbve_pkg::REG_CENTER_Y:     cy_q <= cfg_data_i;
        tbve_pkg::REG_HALF_X:       hx_q <= cfg_data_i[tbve_pkg::HalfW-1:0];
        tbve_pkg::REG_HALF_Y:       hy_q <= cfg_data_i[tbve_pkg::HalfW-1:0];
        tbve_pkg::REG_HALF_Z:       hz_q <= cfg_data_i[tbve_pkg::HalfW-1:0];
        tbve_pkg::REG_LEFT_Z:       lz_q <= cfg_data_i;
        tbve_pkg::REG_RIGHT_Z:      rz_q <= cfg_data_i;
        tbve_pkg::REG_CENTER_BOX_Z: cz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the track and form the bounds.
  always_comb begin
    fx  = in_data_i[22:0];
    fy  = in_data_i[45:23];
    fz  = in_data_i[68:46];
    bx  = in_data_i[91:69];
    by  = in_data_i[114:92];
    bz  = in_data_i[137:115];
    zp  = side_i ? rz_q : lz_q;
    hxs = $signed({3'b000, hx_q});
    hys = $signed({3'b000, hy_q});
    hzs = $signed({3'b000, hz_q});
    f_d.trk.px = fx;
    f_d.trk.py = fy;
    f_d.trk.pz = fz;
    f_d.trk.dx = tbve_pkg::DirW'(bx) - tbve_pkg::DirW'(fx);
    f_d.trk.dy = tbve_pkg::DirW'(by) - tbve_pkg::DirW'(fy);
    f_d.trk.dz = tbve_pkg::DirW'(bz) - tbve_pkg::DirW'(fz);
    f_d.xlo  = tbve_pkg::BoundW'(cx_q) - hxs;
    f_d.xhi  = tbve_pkg::BoundW'(cx_q) + hxs;
    f_d.ylo  = tbve_pkg::BoundW'(cy_q) - hys;
    f_d.yhi  = tbve_pkg::BoundW'(cy_q) + hys;
    f_d.zplo = tbve_pkg::BoundW'(zp) - hzs;
    f_d.zphi = tbve_pkg::BoundW'(zp) + hzs;
    f_d.zclo = tbve_pkg::BoundW'(cz_q) - hzs;
    f_d.zchi = tbve_pkg::BoundW'(cz_q) + hzs;
  end

  // Hand the staged item to the queue when it has room.
  assign push_o     = f_v_q && !full_i;
  assign in_ready_o = !f_v_q || !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign item_o     = f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (in_ready_o) begin
      f_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f_q <= f_d;
    end
  end

endmodule

@@ rtl/tbve_fifo.sv @@
// Short queue between the front and the back part.
// Depends on tbve_pkg for the item type.
module tbve_fifo #(
  parameter int Depth = tbve_pkg::FifoDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tbve_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output tbve_pkg::item_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tbve_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/tbve_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on tbve_pkg for widths.
module tbve_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [tbve_pkg::DivNW-1:0]   n_i,
  input  logic [tbve_pkg::DivDW-1:0]   d_i,
  input  logic                         neg_i,
  output logic [tbve_pkg::QuotW-1:0]   q_o,
  output logic                         ovf_o,
  output logic                         neg_o
);

  localparam int NW = tbve_pkg::DivNW;
  localparam int QW = tbve_pkg::QuotW;

  logic [NW-1:0] rem_q [QW+1];
  logic [NW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];
  logic          neg_q [QW+1];

  // Load and flag quotients too large for the stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_i;
      den_q[0] <= NW'(d_i);
      quo_q[0] <= '0;
      ovf_q[0] <= n_i >= (NW'(d_i) << QW);
      neg_q[0] <= neg_i;
    end
  end

  // Subtract the shifted divisor, one bit per stage.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [NW-1:0] sh;
    logic          ge;
    assign sh = den_q[k-1] << (QW - k);
    assign ge = rem_q[k-1] >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_q[k-1] - sh : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (QW'(ge) << (QW - k));
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign q_o   = quo_q[QW];
  assign ovf_o = ovf_q[QW];
  assign neg_o = neg_q[QW];

endmodule

@@ rtl/tbve_back.sv @@
// Back part: slab tests on both boxes, box choice, rounded vertex, output stage.
// Depends on tbve_pkg and tbve_div.
module tbve_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  tbve_pkg::item_t                item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     out_user_o,
  output logic [tbve_pkg::OutDataW-1:0]  out_data_o
);

  localparam int CW = tbve_pkg::CoordW;
  localparam int DL = tbve_pkg::DivLat;

  typedef struct packed {
    logic                 found;
    logic                 which;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } side_t;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [DL-1:0] dv_q;
  logic m_v_q;
  logic [1:0] m_user_q;
  logic [tbve_pkg::OutDataW-1:0] m_data_q;

  tbve_pkg::track_t t1_q, t2_q, t3_q, t4_q;
  tbve_pkg::slab_t  sx1_q, sy1_q, szp1_q, szc1_q, szp2_q, szc2_q;
  tbve_pkg::frac_t  nxy2_q, fxy2_q;
  logic             okxy2_q;
  tbve_pkg::frac_t  np3_q, fp3_q, nc3_q, fc3_q;
  logic             okp3_q, okc3_q;
  tbve_pkg::frac_t  np4_q, nc4_q;
  logic             hp4_q, hc4_q;
  side_t            s5_q, s6_q;
  logic [tbve_pkg::DirW-1:0] nd5_q;
  logic signed [tbve_pkg::ProdW-1:0] pr5_q [3];
  logic [tbve_pkg::DivNW-1:0] n6_q [3];
  logic [tbve_pkg::DivDW-1:0] d6_q;
  logic neg6_q [3];
  side_t dly_q [DL];

  tbve_pkg::frac_t np3_d, fp3_d, nc3_d, fc3_d, nsel;
  logic signed [tbve_pkg::DirW-1:0] dsel [3];
  logic [tbve_pkg::QuotW-1:0] q [3];
  logic ovf [3];
  logic qneg [3];
  logic signed [CW-1:0] vout [3];
  logic signed [CW-1:0] pout [3];

  // Move the whole pipeline when the output stage can take an item.
  assign en    = !m_v_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      dv_q  <= '0;
      m_v_q <= 1'b0;
    end else if (en) begin
      v1_q  <= !empty_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      dv_q  <= {dv_q[DL-2:0], v6_q};
      m_v_q <= dv_q[DL-1];
    end
  end

  // Fold the z slab of each box into the x/y span; pick the chosen box's entry.
  always_comb begin
    np3_d = tbve_pkg::max_f(nxy2_q, tbve_pkg::near_f(szp2_q));
    fp3_d = tbve_pkg::min_f(fxy2_q, tbve_pkg::far_f(szp2_q));
    nc3_d = tbve_pkg::max_f(nxy2_q, tbve_pkg::near_f(szc2_q));
    fc3_d = tbve_pkg::min_f(fxy2_q, tbve_pkg::far_f(szc2_q));
    nsel  = hp4_q ? np4_q : nc4_q;
    dsel[0] = t4_q.dx;
    dsel[1] = t4_q.dy;
    dsel[2] = t4_q.dz;
  end

  // Slab stages, box choice and dividend setup.
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q   <= item_i.trk;
      sx1_q  <= tbve_pkg::slab_f(item_i.trk.px, item_i.trk.dx, item_i.xlo, item_i.xhi);
      sy1_q  <= tbve_pkg::slab_f(item_i.trk.py, item_i.trk.dy, item_i.ylo, item_i.yhi);
      szp1_q <= tbve_pkg::slab_f(item_i.trk.pz, item_i.trk.dz, item_i.zplo, item_i.zphi);
      szc1_q <= tbve_pkg::slab_f(item_i.trk.pz, item_i.trk.dz, item_i.zclo, item_i.zchi);

      t2_q    <= t1_q;
      nxy2_q  <= tbve_pkg::max_f(tbve_pkg::near_f(sx1_q), tbve_pkg::near_f(sy1_q));
      fxy2_q  <= tbve_pkg::min_f(tbve_pkg::far_f(sx1_q), tbve_pkg::far_f(sy1_q));
      okxy2_q <= sx1_q.ok && sy1_q.ok;
      szp2_q  <= szp1_q;
      szc2_q  <= szc1_q;

      t3_q   <= t2_q;
      np3_q  <= np3_d;
      fp3_q  <= fp3_d;
      nc3_q  <= nc3_d;
      fc3_q  <= fc3_d;
      okp3_q <= okxy2_q && szp2_q.ok;
      okc3_q <= okxy2_q && szc2_q.ok;

      t4_q  <= t3_q;
      np4_q <= np3_q;
      nc4_q <= nc3_q;
      hp4_q <= okp3_q && np3_q.pres && !tbve_pkg::frac_gt(np3_q, fp3_q);
      hc4_q <= okc3_q && nc3_q.pres && !tbve_pkg::frac_gt(nc3_q, fc3_q);

      s5_q.found <= hp4_q || hc4_q;
      s5_q.which <= !hp4_q && hc4_q;
      s5_q.px    <= t4_q.px;
      s5_q.py    <= t4_q.py;
      s5_q.pz    <= t4_q.pz;
      nd5_q      <= nsel.den;
      for (int i = 0; i < 3; i++) begin
        pr5_q[i] <= tbve_pkg::ProdW'(dsel[i]) * tbve_pkg::ProdW'(nsel.num);
      end

      s6_q <= s5_q;
      d6_q <= {nd5_q, 1'b0};
      for (int i = 0; i < 3; i++) begin
        neg6_q[i] <= pr5_q[i][tbve_pkg::ProdW-1];
        n6_q[i]   <= (tbve_pkg::DivNW'(pr5_q[i][tbve_pkg::ProdW-1] ? -pr5_q[i] : pr5_q[i])
                      << 1) + tbve_pkg::DivNW'(nd5_q);
      end

      dly_q[0] <= s6_q;
      for (int k = 1; k < DL; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  // Rounded quotients, one divider per coordinate.
  for (genvar i = 0; i < 3; i++) begin : g_div
    tbve_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (n6_q[i]),
      .d_i   (d6_q),
      .neg_i (neg6_q[i]),
      .q_o   (q[i]),
      .ovf_o (ovf[i]),
      .neg_o (qneg[i])
    );
  end

  assign pout[0] = dly_q[DL-1].px;
  assign pout[1] = dly_q[DL-1].py;
  assign pout[2] = dly_q[DL-1].pz;

  // Add origin, saturate, and zero on a miss.
  for (genvar i = 0; i < 3; i++) begin : g_vtx
    logic [tbve_pkg::QuotW:0]          qv;
    logic signed [tbve_pkg::QuotW+1:0] sq;
    logic signed [tbve_pkg::QuotW+2:0] c;
    always_comb begin
      qv = ovf[i] ? ((tbve_pkg::QuotW+1)'(1) << tbve_pkg::QuotW) : {1'b0, q[i]};
      sq = qneg[i] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      c  = (tbve_pkg::QuotW+3)'(pout[i]) + (tbve_pkg::QuotW+3)'(sq);
      if (!dly_q[DL-1].found)                       vout[i] = '0;
      else if (c < (tbve_pkg::QuotW+3)'(tbve_pkg::VMin)) vout[i] = tbve_pkg::VMin;
      else if (c > (tbve_pkg::QuotW+3)'(tbve_pkg::VMax)) vout[i] = tbve_pkg::VMax;
      else                                          vout[i] = c[CW-1:0];
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_user_q <= {dly_q[DL-1].which, dly_q[DL-1].found};
      m_data_q <= {3'b000, vout[2], vout[1], vout[0]};
    end
  end

  assign out_valid_o = m_v_q;
  assign out_user_o  = m_user_q;
  assign out_data_o  = m_data_q;

endmodule

@@ rtl/tbve_checker.sv @@
// Port-level checks of the track box vertex extrapolator, bound to the top.
// Depends on track_box_vertex_extrapolator_top_defines.svh and tbve_pkg.
`include "track_box_vertex_extrapolator_top_defines.svh"

module tbve_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [tbve_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input logic [1:0]                         m_axis_tuser_o
);

  // Hold a stalled result.
  `TBVE_ASSERT(a_out_hold,
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "stalled result changed")

  // No result during reset.
  `TBVE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

  // A miss carries no box and a zero vertex.
  `TBVE_ASSERT(a_miss_zero,
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> !m_axis_tuser_o[1] && m_axis_tdata_o == '0,
    "miss with nonzero fields")

  // Padding bits stay clear.
  `TBVE_ASSERT(a_pad_zero,
    m_axis_tvalid_o |-> m_axis_tdata_o[tbve_pkg::OutDataW-1:69] == '0,
    "padding set")

endmodule

bind track_box_vertex_extrapolator_top tbve_checker u_tbve_checker (.*);
